[rtl/mlf_pkg.sv]
// ============================================================================
// mlf_pkg: shared types and constants of the multibyte line folder
// Byte range limits of the supported encodings, register indexes and the
// entry that travels from the character splitter to the row placer.
// ============================================================================
package mlf_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COLUMNS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENCODING_MODE = 2'd1;

  localparam logic [7:0] ROW_COLUMNS_RST = 8'd80;

  // encoding modes
  localparam logic [1:0] ENC_AUTO = 2'd0;
  localparam logic [1:0] ENC_EUC  = 2'd1;
  localparam logic [1:0] ENC_SJIS = 2'd2;
  localparam logic [1:0] ENC_UTF8 = 2'd3;

  // byte ranges
  localparam logic [7:0] ASCII_MAX    = 8'h7F;
  localparam logic [7:0] EUC_SS2      = 8'h8E;
  localparam logic [7:0] EUC_LO       = 8'hA1;
  localparam logic [7:0] EUC_HI       = 8'hFE;
  localparam logic [7:0] KANA_LO      = 8'hA1;
  localparam logic [7:0] KANA_HI      = 8'hDF;
  localparam logic [7:0] U8_LEAD2_LO  = 8'hC2;
  localparam logic [7:0] U8_LEAD2_HI  = 8'hDF;
  localparam logic [7:0] U8_LEAD3_LO  = 8'hE0;
  localparam logic [7:0] U8_LEAD3_HI  = 8'hEF;
  localparam logic [7:0] U8_CONT_LO   = 8'h80;
  localparam logic [7:0] U8_CONT_HI   = 8'hBF;
  localparam logic [7:0] SJ_LEAD_A_LO = 8'h81;
  localparam logic [7:0] SJ_LEAD_A_HI = 8'h9F;
  localparam logic [7:0] SJ_LEAD_B_LO = 8'hE0;
  localparam logic [7:0] SJ_LEAD_B_HI = 8'hFC;
  localparam logic [7:0] SJ_TRAIL_A_LO = 8'h40;
  localparam logic [7:0] SJ_TRAIL_A_HI = 8'h7E;
  localparam logic [7:0] SJ_TRAIL_B_LO = 8'h80;
  localparam logic [7:0] SJ_TRAIL_B_HI = 8'hFC;

  // one character (or the end-of-line pad marker) on its way to placement
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  size;
    logic [1:0]  width;
    logic        line_end;
  } char_entry_t;

endpackage

[rtl/mlf_front.sv]
// ============================================================================
// mlf_front: character splitter
// Keeps up to three lookahead bytes, classifies the character at the front of
// the window and pushes it to the queue; drains the window at line end.
// ============================================================================
module mlf_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            encoding_mode,
  input  logic                  in_push,
  input  logic [7:0]            in_byte,
  input  logic                  in_line_last,
  output logic                  in_full,
  input  logic                  q_full,
  output logic                  q_push,
  output mlf_pkg::char_entry_t  q_data
);

  typedef logic [2:0][7:0] window_t;

  window_t     win_r, win_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        flush_r, flush_nxt;

  window_t     acc_w, w, sh;
  logic [1:0]  n, sz_raw, sz, wd;
  logic        accept;

  function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                  input logic [7:0] hi);
    in_rng = (v >= lo) && (v <= hi);
  endfunction

  // returns {size, width}
  function automatic logic [3:0] classify(input window_t cw, input logic [1:0] mode);
    logic u8_two, u8_three, sj_dbl, euc_dbl, euc_kana;
    logic [3:0] r;
    u8_two   = in_rng(cw[0], mlf_pkg::U8_LEAD2_LO, mlf_pkg::U8_LEAD2_HI) &&
               in_rng(cw[1], mlf_pkg::U8_CONT_LO, mlf_pkg::U8_CONT_HI);
    u8_three = in_rng(cw[0], mlf_pkg::U8_LEAD3_LO, mlf_pkg::U8_LEAD3_HI) &&
               in_rng(cw[1], mlf_pkg::U8_CONT_LO, mlf_pkg::U8_CONT_HI) &&
               in_rng(cw[2], mlf_pkg::U8_CONT_LO, mlf_pkg::U8_CONT_HI);
    sj_dbl   = (in_rng(cw[0], mlf_pkg::SJ_LEAD_A_LO, mlf_pkg::SJ_LEAD_A_HI) ||
                in_rng(cw[0], mlf_pkg::SJ_LEAD_B_LO, mlf_pkg::SJ_LEAD_B_HI)) &&
               (in_rng(cw[1], mlf_pkg::SJ_TRAIL_A_LO, mlf_pkg::SJ_TRAIL_A_HI) ||
                in_rng(cw[1], mlf_pkg::SJ_TRAIL_B_LO, mlf_pkg::SJ_TRAIL_B_HI));
    euc_dbl  = in_rng(cw[0], mlf_pkg::EUC_LO, mlf_pkg::EUC_HI) &&
               in_rng(cw[1], mlf_pkg::EUC_LO, mlf_pkg::EUC_HI);
    euc_kana = (cw[0] == mlf_pkg::EUC_SS2) &&
               in_rng(cw[1], mlf_pkg::KANA_LO, mlf_pkg::KANA_HI);
    r = {2'd1, 2'd1};
    unique case (mode)
      mlf_pkg::ENC_AUTO: begin
        if (cw[0] <= mlf_pkg::ASCII_MAX) r = {2'd1, 2'd1};
        else if (u8_three)                       r = {2'd3, 2'd2};
        else if (u8_two || euc_dbl || sj_dbl)    r = {2'd2, 2'd2};
        else if (euc_kana)                       r = {2'd2, 2'd1};
      end
      mlf_pkg::ENC_EUC: begin
        if (euc_kana)     r = {2'd2, 2'd1};
        else if (euc_dbl) r = {2'd2, 2'd2};
      end
      mlf_pkg::ENC_SJIS: begin
        if (!in_rng(cw[0], mlf_pkg::KANA_LO, mlf_pkg::KANA_HI) && sj_dbl)
          r = {2'd2, 2'd2};
      end
      mlf_pkg::ENC_UTF8: begin
        if (u8_two)        r = {2'd2, 2'd2};
        else if (u8_three) r = {2'd3, 2'd2};
      end
      default: r = {2'd1, 2'd1};
    endcase
    classify = r;
  endfunction

  always_comb begin
    // window on accept: pending bytes, then the new byte, zeros after
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < cnt_r)       acc_w[i] = win_r[i];
      else if (2'(i) == cnt_r) acc_w[i] = in_byte;
      else                     acc_w[i] = 8'h00;
    end
    w = flush_r ? win_r : acc_w;
    n = flush_r ? cnt_r : cnt_r + 2'd1;

    {sz_raw, wd} = classify(w, encoding_mode);
    sz = (sz_raw > n) ? n : sz_raw;

    case (sz)
      2'd1:    sh = {8'h00, w[2], w[1]};
      2'd2:    sh = {8'h00, 8'h00, w[2]};
      2'd3:    sh = '0;
      default: sh = w;
    endcase

    q_data.line_end = 1'b0;
    q_data.size     = sz;
    q_data.width    = wd;
    case (sz)
      2'd1:    q_data.bytes = {16'h0000, w[0]};
      2'd2:    q_data.bytes = {8'h00, w[0], w[1]};
      2'd3:    q_data.bytes = {w[0], w[1], w[2]};
      default: q_data.bytes = 24'h000000;
    endcase

    in_full = flush_r || q_full;
    accept  = in_push && !in_full;

    win_nxt   = win_r;
    cnt_nxt   = cnt_r;
    flush_nxt = flush_r;
    q_push    = 1'b0;

    if (flush_r) begin
      if (!q_full) begin
        q_push = 1'b1;
        if (cnt_r != 2'd0) begin
          win_nxt = sh;
          cnt_nxt = cnt_r - sz;
        end else begin
          q_data    = '{bytes: 24'h000000, size: 2'd0, width: 2'd0, line_end: 1'b1};
          flush_nxt = 1'b0;
          win_nxt   = '0;
        end
      end
    end else if (accept) begin
      if (in_line_last) begin
        win_nxt   = acc_w;
        cnt_nxt   = n;
        flush_nxt = 1'b1;
      end else if (n == 2'd3) begin
        q_push  = 1'b1;
        win_nxt = sh;
        cnt_nxt = n - sz;
      end else begin
        win_nxt = acc_w;
        cnt_nxt = n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      cnt_r   <= 2'd0;
      flush_r <= 1'b0;
    end else begin
      win_r   <= win_nxt;
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

[rtl/mlf_queue.sv]
// ============================================================================
// mlf_queue: short FIFO between splitter and placer
// Flop-based ring of character entries; DEPTH is a power of two, >= 2.
// ============================================================================
module mlf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mlf_pkg::char_entry_t  wr_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output mlf_pkg::char_entry_t  rd_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mlf_pkg::char_entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

[rtl/mlf_back.sv]
// ============================================================================
// mlf_back: row placer
// Tracks used columns, decides row breaks and pads, and holds the result
// transaction in an output register until it is popped.
// ============================================================================
module mlf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            row_columns,
  input  logic                  q_valid,
  input  mlf_pkg::char_entry_t  q_data,
  output logic                  q_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [23:0]           out_char_bytes,
  output logic [1:0]            out_char_size,
  output logic [1:0]            out_char_width,
  output logic                  out_row_break,
  output logic [7:0]            out_pad_count,
  output logic                  out_line_done
);

  logic        out_valid_r;
  logic [7:0]  row_used_r, row_used_nxt;
  logic [23:0] bytes_r;
  logic [1:0]  size_r, width_r;
  logic        brk_r, done_r;
  logic [7:0]  pad_r;

  logic        take, over;
  logic [8:0]  sum;
  logic [7:0]  pad_left;

  always_comb begin
    take     = q_valid && (!out_valid_r || out_pop);
    sum      = {1'b0, row_used_r} + {7'd0, q_data.width};
    over     = (row_used_r != 8'd0) && (sum > {1'b0, row_columns});
    pad_left = (row_used_r < row_columns) ? (row_columns - row_used_r) : 8'd0;
    if (q_data.line_end) row_used_nxt = 8'd0;
    else if (over)       row_used_nxt = {6'd0, q_data.width};
    else                 row_used_nxt = sum[7:0];
  end

  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      row_used_r  <= 8'd0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        row_used_r  <= row_used_nxt;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bytes_r <= q_data.bytes;
      size_r  <= q_data.size;
      width_r <= q_data.width;
      done_r  <= q_data.line_end;
      brk_r   <= !q_data.line_end && over;
      if (q_data.line_end || over) pad_r <= pad_left;
      else                         pad_r <= 8'd0;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_char_bytes = bytes_r;
  assign out_char_size  = size_r;
  assign out_char_width = width_r;
  assign out_row_break  = brk_r;
  assign out_pad_count  = pad_r;
  assign out_line_done  = done_r;

endmodule

[rtl/multibyte_line_fold.sv]
// ============================================================================
// multibyte_line_fold: folds a multibyte text line into fixed-width rows
// Results: a character reaches the output through the queue and then the
//   output register once the byte that fills the three-byte lookahead
//   window is accepted; the characters left at line end are drained after
//   the last byte. Throughput: one byte per cycle while in_full is low.
// The byte marked line_last holds the input (full high) while the splitter
//   drains one character per cycle, then the end pad; the drain waits while
//   the queue is full behind a stalled output.
// Reset (rst_n low, synchronous): window, queue, row count and output
//   cleared; row_columns back to 80, encoding_mode to auto.
// ============================================================================
module multibyte_line_fold #(
  parameter int unsigned QUEUE_DEPTH = 2   // power of two, >= 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mlf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // byte input, queue style
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_byte,
  input  logic                            in_line_last,
  // result output, queue style
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [23:0]                     out_char_bytes,
  output logic [1:0]                      out_char_size,
  output logic [1:0]                      out_char_width,
  output logic                            out_row_break,
  output logic [7:0]                      out_pad_count,
  output logic                            out_line_done
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; they are expected only
  // while no line is in flight, so no interlock with the datapath.
  // --------------------------------------------------------------------------
  logic [7:0] row_columns_r;
  logic [1:0] encoding_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_columns_r   <= mlf_pkg::ROW_COLUMNS_RST;
      encoding_mode_r <= mlf_pkg::ENC_AUTO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mlf_pkg::REG_ROW_COLUMNS:   row_columns_r   <= cfg_data;
        mlf_pkg::REG_ENCODING_MODE: encoding_mode_r <= cfg_data[1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front: splits bytes into characters. A character is pushed once three
  // bytes of lookahead exist, so in steady state every accepted byte after
  // the second pushes at most one entry.
  // --------------------------------------------------------------------------
  logic                 q_push, q_full, q_pop, q_valid;
  mlf_pkg::char_entry_t q_wr, q_rd;

  mlf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .encoding_mode (encoding_mode_r),
    .in_push       (in_push),
    .in_byte       (in_byte),
    .in_line_last  (in_line_last),
    .in_full       (in_full),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wr)
  );

  // --------------------------------------------------------------------------
  // Decoupling queue: lets the front keep taking bytes while a result waits
  // on a stalled output.
  // --------------------------------------------------------------------------
  mlf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_data (q_rd)
  );

  // --------------------------------------------------------------------------
  // Back: row accounting and the output register. An entry moves into the
  // output register whenever it is empty or being popped in the same cycle.
  // --------------------------------------------------------------------------
  mlf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .row_columns    (row_columns_r),
    .q_valid        (q_valid),
    .q_data         (q_rd),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_char_bytes (out_char_bytes),
    .out_char_size  (out_char_size),
    .out_char_width (out_char_width),
    .out_row_break  (out_row_break),
    .out_pad_count  (out_pad_count),
    .out_line_done  (out_line_done)
  );

endmodule

[rtl/mlf_checker.sv]
// ============================================================================
// mlf_checker: port-level checks for the line folder
// Watches the top-level ports only; attached with a bind.
// ============================================================================
module mlf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [mlf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [mlf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input logic                            in_push,
  input logic                            in_full,
  input logic [7:0]                      in_byte,
  input logic                            in_line_last,
  input logic                            out_empty,
  input logic                            out_pop,
  input logic [23:0]                     out_char_bytes,
  input logic [1:0]                      out_char_size,
  input logic [1:0]                      out_char_width,
  input logic                            out_row_break,
  input logic [7:0]                      out_pad_count,
  input logic                            out_line_done
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty &&
      $stable({out_char_bytes, out_char_size, out_char_width,
               out_row_break, out_pad_count, out_line_done})))
    else $error("result changed while stalled");

  // end-of-line item carries only the pad
  a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_line_done) |->
      (out_char_size == 2'd0 && out_char_width == 2'd0 && !out_row_break &&
       out_char_bytes == 24'h000000))
    else $error("end item with character fields set");

  // a character item has nonzero size and width
  a_char_item: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_line_done) |->
      (out_char_size != 2'd0 && out_char_width != 2'd0))
    else $error("character item with zero size or width");

  // single-byte character occupies the low byte only
  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_char_size == 2'd1) |-> (out_char_bytes[23:8] == 16'h0000))
    else $error("single-byte character with upper bytes set");

  // line end drains before the next byte is taken
  a_flush_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_line_last) |=> in_full)
    else $error("input not held after line end");

endmodule

bind multibyte_line_fold mlf_checker u_mlf_checker (.*);
